// ===== hw/rtl/bitmap_page_allocator_macros.svh =====
// Assertion helpers for the page allocator.
`ifndef BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`define BITMAP_PAGE_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define BPA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define BPA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hw/rtl/bpa_pkg.sv =====
package bpa_pkg;
    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_NOVIRT = 2'd1,
        ST_NOPHYS = 2'd2,
        ST_BADCNT = 2'd3
    } t_status;

    localparam logic [1:0] CFG_VIRT_BASE = 2'd0;
    localparam logic [1:0] CFG_PHYS_BASE = 2'd1;
    localparam logic [1:0] CFG_POOL      = 2'd2;

    localparam logic [31:0] VIRT_BASE_RST = 32'hC010_0000;
    localparam logic [31:0] PHYS_BASE_RST = 32'h0020_0000;
    localparam logic [12:0] POOL_RST      = 13'd3840;
    localparam int          PAGE_SHIFT    = 12;
endpackage

// ===== hw/rtl/bitmap_page_allocator.sv =====
// Page allocator. A request on i_page_count is taken when i_start is high and
// o_busy is low. Both bitmaps sit in memories holding 8 bits per word and are
// swept one word at a time. After reset a clearing pass over all MAX_PAGES/8
// words zeroes them while o_busy stays high. Once a request is accepted, the
// virtual bitmap is read and scanned word by word to find a free run, and the
// words of that run are then read and written back to mark it. Each page then
// takes a read, scan and write of the physical bitmap, plus another read and
// scan for every full physical word it has to step over. The physical scan
// starts at the lowest word that may still be free, so skipped words are few.
// Results appear one per o_valid strobe and cannot be held off, so the
// receiver must take every result in the cycle it appears. The last result
// of each request has o_last set. Configuration writes are always accepted
// and should only be made while the block is idle.
`include "bitmap_page_allocator_macros.svh"
module bitmap_page_allocator #(
    parameter int MAX_PAGES   = 4096,
    parameter int MAX_REQUEST = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [11:0]          i_page_count,
    output logic                 o_busy,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [1:0]           i_cfg_index,
    input  logic [31:0]          i_cfg_data,
    output logic                 o_valid,
    output logic [1:0]           o_status,
    output logic [31:0]          o_virt_addr,
    output logic [31:0]          o_phys_addr,
    output logic                 o_last
);
    import bpa_pkg::*;

    localparam int WORDS = MAX_PAGES / 8;
    localparam int WW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BW    = $clog2(MAX_PAGES);
    localparam int PW    = BW + 1;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_VRD, S_VSCAN, S_MRK_RD, S_MRK_WR,
        S_PRD, S_PSCAN, S_PWR
    } t_state;

    logic [7:0] r_vmem [WORDS];
    logic [7:0] r_pmem [WORDS];
    logic [7:0] r_vq, r_pq;

    t_state        r_state;
    logic [31:0]   r_virt_base, r_phys_base;
    logic [12:0]   r_pool;
    logic [WW-1:0] r_waddr;
    logic [PW-1:0] r_idx;
    logic [6:0]    r_run;
    logic [6:0]    r_cnt;
    logic [6:0]    r_done;
    logic [BW-1:0] r_vbit;
    logic [WW-1:0] r_pfirst;
    logic          r_valid, r_last;
    logic [1:0]    r_status;
    logic [31:0]   r_va, r_pa;

    logic          v_we, p_we;
    logic [WW-1:0] v_wa, p_wa, v_ra, p_ra;
    logic [7:0]    v_wd, p_wd;

    logic [PW-1:0] len;
    logic [PW-1:0] clip;
    logic [PW-1:0] mark_end;
    logic [6:0]    n_run;
    logic          run_hit;
    logic [2:0]    hit_off;
    logic          p_free;
    logic [2:0]    p_off;
    logic [7:0]    mark_mask;
    logic [PW-1:0] wbase;

    always_comb begin
        clip = (r_pool > 13'(MAX_PAGES)) ? PW'(MAX_PAGES) : PW'(r_pool);
        len  = clip & ~PW'(7);
    end

    assign wbase = {1'b0, r_waddr, 3'b000} >> 0;

    always_comb begin
        logic [6:0] run;
        run     = r_run;
        run_hit = 1'b0;
        hit_off = 3'd0;
        for (int b = 0; b < 8; b++) begin
            if (!run_hit) begin
                if (r_vq[b]) begin
                    run = 7'd0;
                end else begin
                    run = run + 7'd1;
                    if (run == r_cnt) begin
                        run_hit = 1'b1;
                        hit_off = 3'(b);
                    end
                end
            end
        end
        n_run = run;
    end

    always_comb begin
        p_free = 1'b0;
        p_off  = 3'd0;
        for (int b = 7; b >= 0; b--) begin
            if (!r_pq[b]) begin
                p_free = 1'b1;
                p_off  = 3'(b);
            end
        end
    end

    assign mark_end = PW'(r_vbit) + PW'(r_cnt);

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            mark_mask[b] = (wbase + PW'(b) >= PW'(r_vbit)) && (wbase + PW'(b) < mark_end);
        end
    end

    always_comb begin
        v_we = 1'b0; v_wa = r_waddr; v_wd = 8'd0;
        p_we = 1'b0; p_wa = r_waddr; p_wd = 8'd0;
        v_ra = r_waddr; p_ra = r_waddr;
        case (r_state)
            S_CLEAR: begin
                v_we = 1'b1; p_we = 1'b1;
            end
            S_MRK_WR: begin
                v_we = 1'b1; v_wd = r_vq | mark_mask;
            end
            S_PWR: begin
                p_we = 1'b1; p_wd = r_pq | (8'd1 << p_off);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (v_we) r_vmem[v_wa] <= v_wd;
        if (p_we) r_pmem[p_wa] <= p_wd;
        r_vq <= r_vmem[v_ra];
        r_pq <= r_pmem[p_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_virt_base <= VIRT_BASE_RST;
            r_phys_base <= PHYS_BASE_RST;
            r_pool      <= POOL_RST;
            r_waddr     <= '0;
            r_valid     <= 1'b0;
            r_pfirst    <= '0;
            r_idx <= '0; r_run <= '0; r_cnt <= '0; r_done <= '0; r_vbit <= '0;
            r_last <= 1'b0; r_status <= ST_OK; r_va <= '0; r_pa <= '0;
        end else begin
            r_valid <= 1'b0;
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_VIRT_BASE: r_virt_base <= i_cfg_data;
                    CFG_PHYS_BASE: r_phys_base <= i_cfg_data;
                    CFG_POOL:      r_pool      <= i_cfg_data[12:0];
                    default: ;
                endcase
            end
            case (r_state)
                S_CLEAR: begin
                    r_waddr <= r_waddr + WW'(1);
                    if (r_waddr == WW'(WORDS - 1)) begin
                        r_waddr <= '0;
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_cnt   <= 7'(i_page_count);
                        r_run   <= '0;
                        r_idx   <= '0;
                        r_waddr <= '0;
                        r_done  <= '0;
                        if (i_page_count == 12'd0 || i_page_count > 12'(MAX_REQUEST)) begin
                            r_valid <= 1'b1; r_status <= ST_BADCNT;
                            r_va <= '0; r_pa <= '0; r_last <= 1'b1;
                        end else if (len == '0) begin
                            r_valid <= 1'b1; r_status <= ST_NOVIRT;
                            r_va <= '0; r_pa <= '0; r_last <= 1'b1;
                        end else begin
                            r_state <= S_VRD;
                        end
                    end
                end
                S_VRD: r_state <= S_VSCAN;
                S_VSCAN: begin
                    if (run_hit) begin
                        r_vbit  <= BW'(r_idx + PW'(hit_off) + PW'(1) - PW'(r_cnt));
                        r_waddr <= WW'((r_idx + PW'(hit_off) + PW'(1) - PW'(r_cnt)) >> 3);
                        r_state <= S_MRK_RD;
                    end else if (r_idx + PW'(8) >= len) begin
                        r_valid <= 1'b1; r_status <= ST_NOVIRT;
                        r_va <= '0; r_pa <= '0; r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end else begin
                        r_run   <= n_run;
                        r_idx   <= r_idx + PW'(8);
                        r_waddr <= r_waddr + WW'(1);
                        r_state <= S_VRD;
                    end
                end
                S_MRK_RD: r_state <= S_MRK_WR;
                S_MRK_WR: begin
                    if (wbase + PW'(8) >= mark_end) begin
                        r_va    <= r_virt_base + (32'(r_vbit) << PAGE_SHIFT);
                        r_waddr <= r_pfirst;
                        r_state <= S_PRD;
                    end else begin
                        r_waddr <= r_waddr + WW'(1);
                        r_state <= S_MRK_RD;
                    end
                end
                S_PRD: r_state <= S_PSCAN;
                S_PSCAN: begin
                    if (PW'(wbase) >= len) begin
                        r_valid <= 1'b1; r_status <= ST_NOPHYS;
                        r_pa <= '0; r_last <= 1'b1;
                        r_state <= S_IDLE;
                    end else if (p_free) begin
                        r_state <= S_PWR;
                    end else begin
                        r_waddr <= r_waddr + WW'(1);
                        if (r_waddr == WW'(WORDS - 1)) begin
                            r_valid <= 1'b1; r_status <= ST_NOPHYS;
                            r_pa <= '0; r_last <= 1'b1;
                            r_state <= S_IDLE;
                        end else begin
                            r_state <= S_PRD;
                        end
                    end
                end
                S_PWR: begin
                    r_valid  <= 1'b1;
                    r_status <= ST_OK;
                    r_pa     <= r_phys_base + (32'({r_waddr, p_off}) << PAGE_SHIFT);
                    r_last   <= (r_done + 7'd1 == r_cnt);
                    r_done   <= r_done + 7'd1;
                    r_pfirst <= r_waddr;
                    if (r_done + 7'd1 == r_cnt) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_state <= S_PRD;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
            if (r_state == S_PRD && r_done != '0 && r_valid) begin
                r_va <= r_va + 32'(1 << PAGE_SHIFT);
            end
        end
    end

    assign o_busy      = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_virt_addr = r_va;
    assign o_phys_addr = r_pa;
    assign o_last      = r_last;

    `BPA_ASSERT_IMP(a_idle_on_error, i_clk, i_rst_n, r_valid && r_status != ST_OK, r_last)
    `BPA_ASSERT_NXT(a_start_leaves_idle, i_clk, i_rst_n, i_start && !o_busy, r_state != S_CLEAR)
    `BPA_ASSERT_IMP(a_cnt_bound, i_clk, i_rst_n, r_state == S_PWR, r_done < r_cnt)
endmodule
